// ===== hw/rtl/bal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Shared codes, widths and the per-cell control bundle of the array list.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Cell update modes
    localparam logic [1:0] CM_HOLD   = 2'd0;
    localparam logic [1:0] CM_WRITE  = 2'd1;
    localparam logic [1:0] CM_INSERT = 2'd2;
    localparam logic [1:0] CM_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic       rd_load;
        logic       rd_shift;
    } bal_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bal_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bal_cell
// One list entry plus one stage of the read chain toward cell zero.
// ----------------------------------------------------------------------------
module bal_cell
    import bal_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IW    = 6
)
(
    input  wire                clk,
    input  wire  bal_ctrl_t    ctrl,
    input  wire  [IW-1:0]      target,
    input  wire  [DATA_W-1:0]  wr_value,
    input  wire  [DATA_W-1:0]  left_data,
    input  wire  [DATA_W-1:0]  right_data,
    input  wire  [DATA_W-1:0]  right_rd,
    output logic [DATA_W-1:0]  data,
    output logic [DATA_W-1:0]  rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic              hit;
    logic              above;

    assign hit   = (MY_IDX == target);
    assign above = (MY_IDX > target);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            CM_WRITE:
            begin
                if (hit)
                    data_next = wr_value;
            end
            CM_INSERT:
            begin
                if (hit)
                    data_next = wr_value;
                else if (above)
                    data_next = left_data;
            end
            CM_REMOVE:
            begin
                if (hit || above)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Capture the old entry before any shift, then walk it down the chain
    always_comb
    begin
        rd_next = rd_reg;
        if (ctrl.rd_load)
            rd_next = hit ? data_reg : '0;
        else if (ctrl.rd_shift)
            rd_next = right_rd;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_array_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one operation per transfer: s_tuser is the
//   operation code, s_tdata holds position and value. The master channel
//   returns one result per operation: read value, status and count.
//   Set, append, insert, unused-code and failed operations finish in the
//   accept cycle; the result sits in the output register on the next cycle.
//   Insert and remove shift only the entries from the addressed position up.
//   Successful get and remove load the addressed entry into a read chain
//   that moves one cell per cycle toward cell zero; from cell zero the entry
//   enters the output register once that register is free.
//   A new operation is taken only when the previous one has left the cells;
//   while a result waits in the output register the next one is still
//   taken as long as that register is being drained or empty.
//   If the receiver stalls, the result holds and no new operation is
//   taken until the receiver drains it.
//   Reset empties the list (count zero); entries are never cleared and are
//   only read after a write.
// ----------------------------------------------------------------------------
module bounded_array_list
    import bal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // position[31:0], value[63:32]
    input  wire  [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32], count[40:34], zero
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [LW-1:0]         length_reg;
    logic [LW-1:0]         length_next;
    logic [IW-1:0]         cnt_reg;
    logic [IW-1:0]         cnt_next;
    logic [STATUS_W-1:0]   pend_status_reg;
    logic [STATUS_W-1:0]   pend_status_next;
    logic [COUNT_W-1:0]    pend_count_reg;
    logic [COUNT_W-1:0]    pend_count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [47:0]           out_data_reg;
    logic [47:0]           out_data_next;

    logic [OP_W-1:0]       op;
    logic [DATA_W-1:0]     pos;
    logic [DATA_W-1:0]     val;
    logic                  accept;
    logic                  out_free;
    logic                  pos_ok;
    logic                  full;
    logic                  walk;
    logic                  walk_done;
    logic [1:0]            mode;
    logic                  rd_load;
    logic [STATUS_W-1:0]   status;
    logic [LW-1:0]         len_calc;
    logic [IW-1:0]         target;
    bal_ctrl_t             ctrl;

    logic [DATA_W-1:0]     data_w [CAPACITY];
    logic [DATA_W-1:0]     rd_w   [CAPACITY];

    assign op  = s_tuser;
    assign pos = s_tdata[31:0];
    assign val = s_tdata[63:32];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Negative positions have bit 31 set and fail the unsigned compare
    assign pos_ok = pos < {{(DATA_W-LW){1'b0}}, length_reg};
    assign full   = (length_reg == LW'(CAPACITY));
    assign target = (op == OP_APPEND) ? length_reg[IW-1:0] : pos[IW-1:0];

    always_comb
    begin
        mode     = CM_HOLD;
        rd_load  = 1'b0;
        walk     = 1'b0;
        status   = ST_OK;
        len_calc = length_reg;
        case (op)
            OP_GET:
            begin
                if (!pos_ok)
                    status = ST_RANGE;
                else
                begin
                    rd_load = 1'b1;
                    walk    = 1'b1;
                end
            end
            OP_SET:
            begin
                if (!pos_ok)
                    status = ST_RANGE;
                else
                    mode = CM_WRITE;
            end
            OP_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    mode     = CM_WRITE;
                    len_calc = length_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (!pos_ok)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    mode     = CM_INSERT;
                    len_calc = length_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!pos_ok)
                    status = ST_RANGE;
                else
                begin
                    mode     = CM_REMOVE;
                    rd_load  = 1'b1;
                    walk     = 1'b1;
                    len_calc = length_reg - 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign walk_done = (state_reg == S_WALK) && (cnt_reg == '0) && out_free;

    assign ctrl.mode     = accept ? mode : CM_HOLD;
    assign ctrl.rd_load  = accept && rd_load;
    assign ctrl.rd_shift = (state_reg == S_WALK) && (cnt_reg != '0);

    always_comb
    begin
        state_next       = state_reg;
        length_next      = length_reg;
        cnt_next         = cnt_reg;
        pend_status_next = pend_status_reg;
        pend_count_next  = pend_count_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            length_next = len_calc;
            if (walk)
            begin
                state_next       = S_WALK;
                cnt_next         = pos[IW-1:0];
                pend_status_next = status;
                pend_count_next  = COUNT_W'(len_calc);
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = {7'd0, COUNT_W'(len_calc), status, {DATA_W{1'b0}}};
            end
        end
        else if (state_reg == S_WALK)
        begin
            if (cnt_reg != '0)
                cnt_next = cnt_reg - 1'b1;
            else if (walk_done)
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = {7'd0, pend_count_reg, pend_status_reg, rd_w[0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_count_reg  <= pend_count_next;
        out_data_reg    <= out_data_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            logic [DATA_W-1:0] right_r;

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = data_w[gi-1];
            end

            // Last cell keeps its own entry on remove; it is past the end then
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = data_w[gi];
                assign right_r = '0;
            end
            else
            begin : g_mid_r
                assign right_d = data_w[gi+1];
                assign right_r = rd_w[gi+1];
            end

            bal_cell #(
                .INDEX (gi),
                .IW    (IW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .target     (target),
                .wr_value   (val),
                .left_data  (left_d),
                .right_data (right_d),
                .right_rd   (right_r),
                .data       (data_w[gi]),
                .rd         (rd_w[gi])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== tb/sv/bal_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_checker
// Watches both stream channels of the array list and checks every result.
// Each accepted operation is applied to a local copy of the list. The result
// that it should give is queued, and every result transfer is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module bal_checker
    import bal_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // position[31:0], value[63:32]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // read_value[31:0], status[33:32], count[40:34], zero
    output int          errors,
    output int          outstanding,
    output int          held
);

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic [DATA_W-1:0] cells [CAPACITY];
    int unsigned       length;
    list_result_t      awaited [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
        held        = 0;
        length      = 0;
    end

    // Apply one operation to the local list and return the result it gives.
    function automatic list_result_t apply_op(logic [OP_W-1:0] op,
                                              logic [DATA_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
        list_result_t r;
        int unsigned  i;
        r = '0;
        // A negative position reads as a huge unsigned one, so it fails too.
        case (op)
            OP_GET:
            begin
                if (pos >= length)
                    r.status = ST_RANGE;
                else
                    r.read_value = cells[pos];
            end
            OP_SET:
            begin
                if (pos >= length)
                    r.status = ST_RANGE;
                else
                    cells[pos] = val;
            end
            OP_APPEND:
            begin
                if (length >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    cells[length] = val;
                    length++;
                end
            end
            OP_INSERT:
            begin
                // Range check comes before the full check.
                if (pos >= length)
                    r.status = ST_RANGE;
                else if (length >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = length; i > pos; i--)
                        cells[i] = cells[i - 1];
                    cells[pos] = val;
                    length++;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= length)
                    r.status = ST_RANGE;
                else
                begin
                    r.read_value = cells[pos];
                    for (i = pos; i + 1 < length; i++)
                        cells[i] = cells[i + 1];
                    length--;
                end
            end
            default:
            begin
                // Unused codes leave everything alone.
            end
        endcase
        r.count = COUNT_W'(length);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        list_result_t want;
        list_result_t got;
        if (rst_n)
        begin
            // Results first: a result never belongs to an operation taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                got.read_value = m_tdata[31:0];
                got.status     = m_tdata[33:32];
                got.count      = m_tdata[40:34];
                if (awaited.size() == 0)
                begin
                    $error("unexpected result: read_value %0d, status %0d, count %0d",
                           $signed(got.read_value), got.status, got.count);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, got.status);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, got.count);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited.push_back(apply_op(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            outstanding = awaited.size();
            held        = length;
        end
    end

endmodule

// ===== tb/sv/tb_bounded_array_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list
// Stimulus and verdict for the bounded array list.
// A directed run covers empty, boundary and bad positions, extreme values
// and the unused codes. Random operations then grow the list toward full
// and shrink it, with idle input cycles and output stalls in two phases, none in the last.
// ----------------------------------------------------------------------------
module tb_bounded_array_list
    import bal_pkg::*;
();

    localparam int CAPACITY   = 64;
    localparam int PHASE_OPS  = 167;
    localparam int DRAIN_WAIT = 80;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // position[31:0], value[63:32]
    logic [2:0]  s_tuser;    // operation[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // read_value[31:0], status[33:32], count[40:34], zero

    int errors;
    int outstanding;
    int held;
    int src_idle_pct;
    int sink_idle_pct;
    bit growing;

    bounded_array_list #(.CAPACITY(CAPACITY)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bal_checker #(.CAPACITY(CAPACITY)) list_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .held        (held)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver stalls at random.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(logic [OP_W-1:0] op, logic [31:0] pos, logic [31:0] val);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Grow toward full, then shrink toward empty; content and positions random.
    task automatic send_random_op();
        logic [OP_W-1:0] op;
        logic [31:0]     pos;
        int              pick;
        if (held >= CAPACITY && $urandom_range(0, 5) == 0)
            growing = 1'b0;
        else if (held == 0 || $urandom_range(0, 59) == 0)
            growing = ~growing | (held == 0);
        pick = $urandom_range(0, 99);
        if (growing)
            op = (pick < 35) ? OP_APPEND : (pick < 55) ? OP_INSERT :
                 (pick < 70) ? OP_GET    : (pick < 82) ? OP_SET    :
                 (pick < 92) ? OP_REMOVE : OP_W'($urandom_range(5, 7));
        else
            op = (pick < 8)  ? OP_APPEND : (pick < 16) ? OP_INSERT :
                 (pick < 36) ? OP_GET    : (pick < 48) ? OP_SET    :
                 (pick < 95) ? OP_REMOVE : OP_W'($urandom_range(5, 7));
        pick = $urandom_range(0, 99);
        if (pick < 75 && held > 0)
            pos = $urandom_range(0, held - 1);
        else if (pick < 83)
            pos = held;
        else if (pick < 88)
            pos = 32'hFFFF_FFFF;
        else if (pick < 94)
            pos = $urandom;
        else
            pos = $urandom_range(0, 2 * CAPACITY);
        send_op(op, pos, $urandom);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        src_idle_pct  = 8;
        sink_idle_pct = 45;
        growing       = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty list: every indexed operation is out of range; then append extreme values and read two back.
        send_op(OP_GET,    32'd0, 32'd0);
        send_op(OP_REMOVE, 32'd0, 32'd0);
        send_op(OP_INSERT, 32'd0, 32'h1111_1111);
        send_op(OP_SET,    32'd0, 32'h2222_2222);
        send_op(OP_APPEND, $urandom, 32'h7FFF_FFFF);
        send_op(OP_APPEND, $urandom, 32'h8000_0000);
        send_op(OP_APPEND, $urandom, 32'h0000_0000);
        send_op(OP_APPEND, $urandom, 32'hFFFF_FFFF);
        send_op(OP_GET,    32'd0, 32'd0);
        send_op(OP_GET,    32'd3, $urandom);
        // Bad positions: one past the end, negative, extremes; then sets and inserts at valid positions.
        send_op(OP_GET,    32'd4, 32'd0);
        send_op(OP_GET,    32'hFFFF_FFFF, 32'd0);
        send_op(OP_GET,    32'h8000_0000, 32'd0);
        send_op(OP_GET,    32'h7FFF_FFFF, 32'd0);
        send_op(OP_SET,    32'd1, 32'h5555_5555);
        send_op(OP_SET,    32'd3, 32'hAAAA_AAAA);
        send_op(OP_INSERT, 32'd0, 32'h1234_5678);
        send_op(OP_INSERT, 32'd4, 32'h8765_4321);
        // Insert at the end position is rejected.
        send_op(OP_INSERT, 32'd6, 32'hDEAD_BEEF);
        send_op(OP_REMOVE, 32'd5, 32'd0);
        send_op(OP_REMOVE, 32'd0, 32'd0);
        send_op(OP_W'(5), 32'd0, 32'hFFFF_FFFF);
        send_op(OP_W'(6), 32'hFFFF_FFFF, 32'd0);
        send_op(OP_W'(7), $urandom, $urandom);
        send_op(OP_REMOVE, 32'h8000_0000, 32'd0);

        repeat (PHASE_OPS) send_random_op();
        src_idle_pct  = 45;
        sink_idle_pct = 8;
        repeat (PHASE_OPS) send_random_op();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (PHASE_OPS) send_random_op();
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
